/* rtl/core/ata_pkg.sv */
package ata_pkg;

    localparam int NUM_ANCHORS = 5;
    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DVS_W = 16;

    localparam logic [15:0] LN2_Q16 = 16'd45426;
    localparam logic [14:0] COUNT_MAX = 15'h7fff;

    // anchor widths and heights in pixels
    localparam logic [7:0] ANC_W [NUM_ANCHORS] = '{8'd130, 8'd211, 8'd153, 8'd125, 8'd97};
    localparam logic [8:0] ANC_H [NUM_ANCHORS] = '{9'd130, 9'd211, 9'd306, 9'd375, 9'd388};

    // anchor area in Q.8 square pixels
    localparam logic [23:0] ANC_AREA [NUM_ANCHORS] =
        '{24'd4326400, 24'd11397376, 24'd11985408, 24'd12000000, 24'd9634816};

    typedef struct packed {
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_op_t;

    // log2 in Q.16 by repeated squaring, evaluated at elaboration only
    function automatic logic [19:0] log2q16(input int unsigned x);
        int unsigned e;
        longint unsigned m;
        logic [15:0] frac;
        e = 0;
        for (int i = 1; i < 17; i++)
        begin
            if (x >= (32'd1 << i))
                e = i;
        end
        m = longint'(x) << (30 - e);
        frac = '0;
        for (int b = 15; b >= 0; b--)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31))
            begin
                m = m >> 1;
                frac[b] = 1'b1;
            end
        end
        return {e[3:0], frac};
    endfunction

    localparam logic [19:0] LOG_AW [NUM_ANCHORS] =
        '{log2q16(2080), log2q16(3376), log2q16(2448), log2q16(2000), log2q16(1552)};
    localparam logic [19:0] LOG_AH [NUM_ANCHORS] =
        '{log2q16(2080), log2q16(3376), log2q16(4896), log2q16(6000), log2q16(6208)};

endpackage

/* rtl/core/ata_mul.sv */
module ata_mul (
    input  logic                         clk,
    input  ata_pkg::mul_op_t             op,
    output logic [ata_pkg::MUL_P_W-1:0]  prod_reg
);
    import ata_pkg::*;

    always_ff @(posedge clk)
    begin
        prod_reg <= MUL_P_W'(op.a) * MUL_P_W'(op.b);
    end

endmodule

/* rtl/core/ata_div.sv */
module ata_div #(
    parameter int DIVD_W = 28
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [DIVD_W-1:0]            dividend,
    input  logic [ata_pkg::DVS_W-1:0]    divisor,
    output logic                         busy,
    output logic                         done,
    output logic [DIVD_W-1:0]            quotient,
    output logic [ata_pkg::DVS_W-1:0]    remainder
);
    import ata_pkg::*;

    localparam int CNT_W = (DIVD_W > 1) ? $clog2(DIVD_W) : 1;

    logic [DIVD_W-1:0] quo_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DVS_W:0]    shifted;
    logic              ge;

    assign shifted = {rem_reg, quo_reg[DIVD_W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIVD_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            cnt_reg <= cnt_reg - 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // one restoring step per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVD_W-2:0], ge};
            if (ge)
                rem_reg <= DVS_W'(shifted - {1'b0, dvs_reg});
            else
                rem_reg <= shifted[DVS_W-1:0];
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/core/anchor_target_assigner_top.sv */
// Assigns a region-proposal training target to one score-map cell per item. The cell is
// mapped to an image point (stride CELL_STRIDE, half-stride offset, divided by image_scale),
// tested against the target's centre of mass, and for a positive cell the best of five
// fixed anchors by IoU is chosen and its centre offsets and log size ratios (Q4.12) are
// produced, with a running count of positives. Everything runs on one shared registered
// multiplier and one bit-per-cycle divider under a sequencer: an item takes two point
// divisions and a short distance test when the cell is not positive; a positive cell adds
// anchor matching, two offset divisions and two log evaluations. in_ready is high only
// between items; a finished item waits in the output register while the next one is
// accepted. Write configuration only while idle.
module anchor_target_assigner_top #(
    parameter int MAX_COLS    = 128,
    parameter int MAX_ROWS    = 128,
    parameter int CELL_STRIDE = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [6:0]         cell_col,
    input  logic [6:0]         cell_row,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               is_positive,
    output logic [2:0]         best_anchor,
    output logic signed [15:0] offset_x,
    output logic signed [15:0] offset_y,
    output logic signed [15:0] log_width_ratio,
    output logic signed [15:0] log_height_ratio,
    output logic [14:0]        positive_total
);
    import ata_pkg::*;

    localparam int PC_W  = $clog2(127 * CELL_STRIDE + CELL_STRIDE / 2 + 1);
    localparam int PNT_W = PC_W + 16;
    localparam int DIV_W = (PNT_W > 28) ? PNT_W : 28;

    localparam logic [2:0] REG_LEFT   = 3'd0;
    localparam logic [2:0] REG_TOP    = 3'd1;
    localparam logic [2:0] REG_WIDTH  = 3'd2;
    localparam logic [2:0] REG_HEIGHT = 3'd3;
    localparam logic [2:0] REG_MCX    = 3'd4;
    localparam logic [2:0] REG_MCY    = 3'd5;
    localparam logic [2:0] REG_DLIM   = 3'd6;
    localparam logic [2:0] REG_SCALE  = 3'd7;

    typedef enum logic [25:0] {
        S_IDLE   = 26'b1 << 0,
        S_DIVX   = 26'b1 << 1,
        S_DIVY   = 26'b1 << 2,
        S_DIST   = 26'b1 << 3,
        S_DX2    = 26'b1 << 4,
        S_DY2    = 26'b1 << 5,
        S_LIM2   = 26'b1 << 6,
        S_TAREA  = 26'b1 << 7,
        S_OVL    = 26'b1 << 8,
        S_UNION  = 26'b1 << 9,
        S_X1     = 26'b1 << 10,
        S_X2     = 26'b1 << 11,
        S_X3     = 26'b1 << 12,
        S_X4     = 26'b1 << 13,
        S_X5     = 26'b1 << 14,
        S_PREOFF = 26'b1 << 15,
        S_OFFX   = 26'b1 << 16,
        S_OFFY   = 26'b1 << 17,
        S_LOGI   = 26'b1 << 18,
        S_SQA    = 26'b1 << 19,
        S_SQB    = 26'b1 << 20,
        S_SQC    = 26'b1 << 21,
        S_SQD    = 26'b1 << 22,
        S_LNMUL  = 26'b1 << 23,
        S_LNFIN  = 26'b1 << 24,
        S_DONE   = 26'b1 << 25
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [15:0] tleft_reg, ttop_reg, twid_reg, thgt_reg;
    logic [15:0] mcx_reg, mcy_reg, dlim_reg, scale_reg;

    // working registers
    logic [6:0]        col_reg, row_reg;
    logic [PNT_W-1:0]  px_reg, py_reg;
    logic [61:0]       acc_reg, acc2_reg;
    logic [31:0]       tarea_reg;
    logic [2:0]        k_reg, best_reg;
    logic [24:0]       ov_reg, best_ov_reg;
    logic [32:0]       un_reg, best_un_reg;
    logic              best_valid_reg;
    logic              pos_reg;
    logic              neg_reg;
    logic              dneg_reg;
    logic              lsel_reg;
    logic [3:0]        e_reg, bit_reg;
    logic [30:0]       m_reg;
    logic [15:0]       frac_reg;
    logic [15:0]       offx_reg, offy_reg, logw_reg, logh_reg;
    logic [14:0]       cnt_reg, cnt_next;

    // output register
    logic              out_valid_reg;
    logic              out_pos_reg;
    logic [2:0]        out_best_reg;
    logic [15:0]       out_offx_reg, out_offy_reg, out_logw_reg, out_logh_reg;
    logic [14:0]       out_total_reg;

    // shared units
    mul_op_t             mul_op;
    logic [MUL_P_W-1:0]  prod;
    logic                div_start, div_busy, div_done;
    logic [DIV_W-1:0]    div_dividend, div_quo;
    logic [DVS_W-1:0]    div_divisor, div_rem;

    ata_mul u_mul (
        .clk      (clk),
        .op       (mul_op),
        .prod_reg (prod)
    );

    ata_div #(.DIVD_W(DIV_W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    function automatic logic [DIV_W-1:0] cell_num(input logic [6:0] c);
        return DIV_W'({PC_W'(int'(c) * CELL_STRIDE + CELL_STRIDE / 2), 16'd0});
    endfunction

    function automatic logic [15:0] sat_floor(input logic neg, input logic [DIV_W-1:0] q,
                                              input logic rnz);
        logic [DIV_W:0] mag;
        mag = {1'b0, q} + (DIV_W + 1)'(rnz);
        if (!neg)
            return (q > DIV_W'(32767)) ? 16'h7fff : q[15:0];
        else
            return (mag > (DIV_W + 1)'(32768)) ? 16'h8000 : 16'(~mag[15:0] + 16'd1);
    endfunction

    // ---------------------------------------------------------------- datapath logic
    logic        in_fire, out_load;
    logic [15:0] scale_eff;

    logic signed [PNT_W:0] dx, dy;
    logic [PNT_W:0]        adx, ady;
    logic                  far, grid_out;

    logic signed [20:0] px_s, py_s, hx, lx, hy, ly, ox_d, oy_d;
    logic [11:0]        ox;
    logic [12:0]        oy;
    logic [10:0]        aw8;
    logic [11:0]        ah8;

    logic [32:0] un_c;
    logic        valid_c, first_c, cross_c, better_u, last_k;
    logic [61:0] rhs_c;
    logic        better_x;

    logic [7:0]         wa_b;
    logic [8:0]         ha_b;
    logic signed [20:0] sx, sy;
    logic [28:0]        nx, ny;
    logic [27:0]        magx, magy;

    logic [15:0] lx_val;
    logic [3:0]  e_c;
    logic [30:0] m_c;
    logic [61:0] sq_sum;
    logic [31:0] mn;

    logic [19:0] lc;
    logic [20:0] dl;
    logic [19:0] dmag;
    logic [37:0] sv;
    logic [37:0] sr;
    logic signed [17:0] rq;
    logic [15:0] ln_res;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign scale_eff = (scale_reg == 16'd0) ? 16'd1 : scale_reg;

    assign dx  = $signed({{(PNT_W - 15){1'b0}}, mcx_reg}) - $signed({1'b0, px_reg});
    assign dy  = $signed({{(PNT_W - 15){1'b0}}, mcy_reg}) - $signed({1'b0, py_reg});
    assign adx = dx[PNT_W] ? (PNT_W + 1)'(-dx) : dx;
    assign ady = dy[PNT_W] ? (PNT_W + 1)'(-dy) : dy;
    assign far = (|adx[PNT_W:16]) || (|ady[PNT_W:16]);
    assign grid_out = ({4'd0, col_reg} >= 11'(MAX_COLS)) || ({4'd0, row_reg} >= 11'(MAX_ROWS));

    // overlap of anchor k with the target; the point is below 2^18 once positive
    assign aw8  = {ANC_W[k_reg], 3'd0};
    assign ah8  = {ANC_H[k_reg], 3'd0};
    assign px_s = $signed({3'd0, px_reg[17:0]});
    assign py_s = $signed({3'd0, py_reg[17:0]});

    always_comb
    begin
        logic signed [20:0] tr, tb, ar, al, ab, at;
        tr = $signed(21'({5'd0, tleft_reg}) + 21'({5'd0, twid_reg}));
        tb = $signed(21'({5'd0, ttop_reg}) + 21'({5'd0, thgt_reg}));
        ar = px_s + $signed({10'd0, aw8});
        al = px_s - $signed({10'd0, aw8});
        ab = py_s + $signed({9'd0, ah8});
        at = py_s - $signed({9'd0, ah8});
        hx = (tr < ar) ? tr : ar;
        lx = ($signed({5'd0, tleft_reg}) > al) ? $signed({5'd0, tleft_reg}) : al;
        hy = (tb < ab) ? tb : ab;
        ly = ($signed({5'd0, ttop_reg}) > at) ? $signed({5'd0, ttop_reg}) : at;
        ox_d = hx - lx;
        oy_d = hy - ly;
    end

    assign ox = (ox_d > 21'sd0) ? ox_d[11:0] : 12'd0;
    assign oy = (oy_d > 21'sd0) ? oy_d[12:0] : 13'd0;

    assign un_c    = 33'(tarea_reg) + 33'(ANC_AREA[k_reg]) - 33'(prod[24:0]);
    assign valid_c = un_c >= 33'd3;
    assign first_c = (k_reg == 3'd0);
    assign cross_c = !first_c && valid_c && best_valid_reg;
    assign better_u = first_c || (valid_c && !best_valid_reg);
    assign last_k  = (k_reg == 3'(NUM_ANCHORS - 1));
    assign rhs_c   = acc2_reg + (62'(prod[41:0]) << 17);
    assign better_x = acc_reg > rhs_c;

    // offset numerators: 2*(2*edge + size - 2*point)*128 + anchor, over 2*anchor
    assign wa_b = ANC_W[best_reg];
    assign ha_b = ANC_H[best_reg];
    assign sx = $signed({4'd0, tleft_reg, 1'b0}) + $signed({5'd0, twid_reg})
              - $signed({2'd0, px_reg[17:0], 1'b0});
    assign sy = $signed({4'd0, ttop_reg, 1'b0}) + $signed({5'd0, thgt_reg})
              - $signed({2'd0, py_reg[17:0], 1'b0});
    assign nx = {sx, 8'd0} + 29'(wa_b);
    assign ny = {sy, 8'd0} + 29'(ha_b);
    assign magx = nx[28] ? 28'(~nx + 29'd1) : nx[27:0];
    assign magy = ny[28] ? 28'(~ny + 29'd1) : ny[27:0];

    // log2 set-up and squaring
    assign lx_val = lsel_reg ? thgt_reg : twid_reg;

    always_comb
    begin
        e_c = 4'd0;
        for (int i = 1; i < 16; i++)
        begin
            if (lx_val[i])
                e_c = 4'(i);
        end
    end

    assign m_c    = {lx_val, 15'd0} << (4'd15 - e_c);
    assign sq_sum = acc_reg + 62'(prod[29:0]);
    assign mn     = sq_sum[61:30];

    assign lc   = lsel_reg ? LOG_AH[best_reg] : LOG_AW[best_reg];
    assign dl   = {1'b0, e_reg, frac_reg} - {1'b0, lc};
    assign dmag = dl[20] ? 20'(-dl) : dl[19:0];
    assign sv   = dneg_reg ? 38'(-{2'd0, prod[35:0]}) : {2'd0, prod[35:0]};
    assign sr   = sv + 38'd524288;
    assign rq   = $signed(sr[37:20]);
    assign ln_res = (rq > 18'sd32767) ? 16'h7fff :
                    (rq < -18'sd32768) ? 16'h8000 : rq[15:0];

    assign cnt_next = (pos_reg && cnt_reg != COUNT_MAX) ? cnt_reg + 15'd1 : cnt_reg;

    // ---------------------------------------------------------------- shared unit operands
    always_comb
    begin
        mul_op = '0;
        unique case (state_reg)
            S_DIST:  mul_op = '{a: MUL_A_W'(adx[15:0]), b: MUL_B_W'(adx[15:0])};
            S_DX2:   mul_op = '{a: MUL_A_W'(ady[15:0]), b: MUL_B_W'(ady[15:0])};
            S_DY2:   mul_op = '{a: MUL_A_W'(dlim_reg), b: MUL_B_W'(dlim_reg)};
            S_LIM2:  mul_op = '{a: MUL_A_W'(twid_reg), b: MUL_B_W'(thgt_reg)};
            S_OVL:   mul_op = '{a: MUL_A_W'(ox), b: MUL_B_W'(oy)};
            S_X1:    mul_op = '{a: MUL_A_W'(ov_reg), b: MUL_B_W'(best_un_reg[16:0])};
            S_X2:    mul_op = '{a: MUL_A_W'(ov_reg), b: MUL_B_W'(best_un_reg[32:17])};
            S_X3:    mul_op = '{a: MUL_A_W'(best_ov_reg), b: MUL_B_W'(un_reg[16:0])};
            S_X4:    mul_op = '{a: MUL_A_W'(best_ov_reg), b: MUL_B_W'(un_reg[32:17])};
            S_SQA:   mul_op = '{a: MUL_A_W'(m_reg[30:15]), b: MUL_B_W'(m_reg[30:15])};
            S_SQB:   mul_op = '{a: MUL_A_W'(m_reg[30:15]), b: MUL_B_W'(m_reg[14:0])};
            S_SQC:   mul_op = '{a: MUL_A_W'(m_reg[14:0]), b: MUL_B_W'(m_reg[14:0])};
            S_LNMUL: mul_op = '{a: MUL_A_W'(dmag), b: MUL_B_W'(LN2_Q16)};
            default: mul_op = '0;
        endcase
    end

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = cell_num(cell_col);
        div_divisor  = scale_eff;
        unique case (state_reg)
            S_IDLE:
            begin
                div_start = in_fire;
            end
            S_DIVX:
            begin
                div_start    = div_done;
                div_dividend = cell_num(row_reg);
            end
            S_PREOFF:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(magx);
                div_divisor  = {7'd0, wa_b, 1'b0};
            end
            S_OFFX:
            begin
                div_start    = div_done;
                div_dividend = DIV_W'(magy);
                div_divisor  = {6'd0, ha_b, 1'b0};
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_fire) state_next = S_DIVX;
            S_DIVX:   if (div_done) state_next = S_DIVY;
            S_DIVY:   if (div_done) state_next = S_DIST;
            S_DIST:   state_next = (far || grid_out) ? S_DONE : S_DX2;
            S_DX2:    state_next = S_DY2;
            S_DY2:    state_next = S_LIM2;
            S_LIM2:   state_next = (acc_reg > 62'(prod[31:0])) ? S_DONE : S_TAREA;
            S_TAREA:  state_next = S_OVL;
            S_OVL:    state_next = S_UNION;
            S_UNION:
            begin
                if (cross_c)
                    state_next = S_X1;
                else
                    state_next = last_k ? S_PREOFF : S_OVL;
            end
            S_X1:     state_next = S_X2;
            S_X2:     state_next = S_X3;
            S_X3:     state_next = S_X4;
            S_X4:     state_next = S_X5;
            S_X5:     state_next = last_k ? S_PREOFF : S_OVL;
            S_PREOFF: state_next = S_OFFX;
            S_OFFX:   if (div_done) state_next = S_OFFY;
            S_OFFY:   if (div_done) state_next = S_LOGI;
            S_LOGI:
            begin
                if (lx_val != 16'd0)
                    state_next = S_SQA;
                else if (lsel_reg)
                    state_next = S_DONE;
            end
            S_SQA:    state_next = S_SQB;
            S_SQB:    state_next = S_SQC;
            S_SQC:    state_next = S_SQD;
            S_SQD:    state_next = (bit_reg == 4'd0) ? S_LNMUL : S_SQA;
            S_LNMUL:  state_next = S_LNFIN;
            S_LNFIN:  state_next = lsel_reg ? S_DONE : S_LOGI;
            S_DONE:   if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            tleft_reg     <= '0;
            ttop_reg      <= '0;
            twid_reg      <= '0;
            thgt_reg      <= '0;
            mcx_reg       <= '0;
            mcy_reg       <= '0;
            dlim_reg      <= '0;
            scale_reg     <= 16'd4096;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                cnt_reg       <= cnt_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LEFT:   tleft_reg <= cfg_data;
                    REG_TOP:    ttop_reg  <= cfg_data;
                    REG_WIDTH:  twid_reg  <= cfg_data;
                    REG_HEIGHT: thgt_reg  <= cfg_data;
                    REG_MCX:    mcx_reg   <= cfg_data;
                    REG_MCY:    mcy_reg   <= cfg_data;
                    REG_DLIM:   dlim_reg  <= cfg_data;
                    REG_SCALE:  scale_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- working registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    col_reg <= cell_col;
                    row_reg <= cell_row;
                    pos_reg <= 1'b1;
                end
            end
            S_DIVX:
            begin
                if (div_done)
                    px_reg <= div_quo[PNT_W-1:0];
            end
            S_DIVY:
            begin
                if (div_done)
                    py_reg <= div_quo[PNT_W-1:0];
            end
            S_DIST:
            begin
                if (far || grid_out)
                    pos_reg <= 1'b0;
            end
            S_DX2:
            begin
                acc_reg <= 62'(prod[31:0]);
            end
            S_DY2:
            begin
                acc_reg <= acc_reg + 62'(prod[31:0]);
            end
            S_LIM2:
            begin
                if (acc_reg > 62'(prod[31:0]))
                    pos_reg <= 1'b0;
            end
            S_TAREA:
            begin
                tarea_reg <= prod[31:0];
                k_reg     <= 3'd0;
            end
            S_UNION:
            begin
                ov_reg <= prod[24:0];
                un_reg <= un_c;
                if (!cross_c)
                begin
                    if (better_u)
                    begin
                        best_reg       <= k_reg;
                        best_valid_reg <= valid_c;
                        best_ov_reg    <= prod[24:0];
                        best_un_reg    <= valid_c ? un_c : 33'd1;
                    end
                    k_reg <= k_reg + 3'd1;
                end
            end
            S_X2:
            begin
                acc_reg <= 62'(prod[41:0]);
            end
            S_X3:
            begin
                acc_reg <= acc_reg + (62'(prod[41:0]) << 17);
            end
            S_X4:
            begin
                acc2_reg <= 62'(prod[41:0]);
            end
            S_X5:
            begin
                // strict greater replaces, so the earlier anchor keeps a tie
                if (better_x)
                begin
                    best_reg       <= k_reg;
                    best_valid_reg <= 1'b1;
                    best_ov_reg    <= ov_reg;
                    best_un_reg    <= un_reg;
                end
                k_reg <= k_reg + 3'd1;
            end
            S_PREOFF:
            begin
                neg_reg <= nx[28];
            end
            S_OFFX:
            begin
                if (div_done)
                begin
                    offx_reg <= sat_floor(neg_reg, div_quo, div_rem != '0);
                    neg_reg  <= ny[28];
                end
            end
            S_OFFY:
            begin
                if (div_done)
                begin
                    offy_reg <= sat_floor(neg_reg, div_quo, div_rem != '0);
                    lsel_reg <= 1'b0;
                end
            end
            S_LOGI:
            begin
                if (lx_val == 16'd0)
                begin
                    if (lsel_reg)
                        logh_reg <= 16'h8000;
                    else
                        logw_reg <= 16'h8000;
                    lsel_reg <= 1'b1;
                end
                else
                begin
                    e_reg    <= e_c;
                    m_reg    <= m_c;
                    frac_reg <= '0;
                    bit_reg  <= 4'd15;
                end
            end
            S_SQB:
            begin
                acc_reg <= 62'(prod[31:0]) << 30;
            end
            S_SQC:
            begin
                acc_reg <= acc_reg + (62'(prod[30:0]) << 16);
            end
            S_SQD:
            begin
                // renormalise the mantissa and take one fraction bit
                if (mn[31])
                begin
                    m_reg              <= mn[31:1];
                    frac_reg[bit_reg]  <= 1'b1;
                end
                else
                begin
                    m_reg <= mn[30:0];
                end
                bit_reg <= bit_reg - 4'd1;
            end
            S_LNMUL:
            begin
                dneg_reg <= dl[20];
            end
            S_LNFIN:
            begin
                if (lsel_reg)
                    logh_reg <= ln_res;
                else
                    logw_reg <= ln_res;
                lsel_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_pos_reg   <= pos_reg;
            out_best_reg  <= pos_reg ? best_reg : 3'd0;
            out_offx_reg  <= pos_reg ? offx_reg : 16'd0;
            out_offy_reg  <= pos_reg ? offy_reg : 16'd0;
            out_logw_reg  <= pos_reg ? logw_reg : 16'd0;
            out_logh_reg  <= pos_reg ? logh_reg : 16'd0;
            out_total_reg <= cnt_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign is_positive      = out_pos_reg;
    assign best_anchor      = out_best_reg;
    assign offset_x         = out_offx_reg;
    assign offset_y         = out_offy_reg;
    assign log_width_ratio  = out_logw_reg;
    assign log_height_ratio = out_logh_reg;
    assign positive_total   = out_total_reg;

    // ---------------------------------------------------------------- assertions
    a_best_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (best_anchor < 3'(NUM_ANCHORS)))
        else $error("best anchor out of range");

    a_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_positive) |->
            (best_anchor == 3'd0 && offset_x == 16'sd0 && offset_y == 16'sd0 &&
             log_width_ratio == 16'sd0 && log_height_ratio == 16'sd0))
        else $error("negative item carries targets");

    a_cnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (cnt_reg == $past(cnt_next)) && (cnt_reg >= $past(cnt_reg)))
        else $error("positive count went backwards");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_DIVX) && div_busy)
        else $error("accepted item did not start the point division");

endmodule

/* verif/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 6000;
    localparam int DRAIN_CYCLES = 400;

    // register indexes
    localparam logic [2:0] REG_LEFT   = 3'd0;
    localparam logic [2:0] REG_TOP    = 3'd1;
    localparam logic [2:0] REG_WIDTH  = 3'd2;
    localparam logic [2:0] REG_HEIGHT = 3'd3;
    localparam logic [2:0] REG_MASS_X = 3'd4;
    localparam logic [2:0] REG_MASS_Y = 3'd5;
    localparam logic [2:0] REG_LIMIT  = 3'd6;
    localparam logic [2:0] REG_SCALE  = 3'd7;

    localparam longint ANCHOR_RATIO [5] = '{1, 1, 2, 3, 4};
    localparam longint ANCHOR_WIDTH [5] = '{130, 211, 153, 125, 97};

    typedef struct packed {
        logic [6:0] col;
        logic [6:0] row;
    } cell_t;

    typedef struct packed {
        logic        pos;
        logic [2:0]  anchor;
        logic [15:0] off_x;
        logic [15:0] off_y;
        logic [15:0] log_w;
        logic [15:0] log_h;
        logic [14:0] total;
    } target_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [6:0] cell_col = '0;
    logic [6:0] cell_row = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic is_positive;
    logic [2:0] best_anchor;
    logic signed [15:0] offset_x, offset_y, log_width_ratio, log_height_ratio;
    logic [14:0] positive_total;

    anchor_target_assigner_top dut (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    cell_t   cell_q [$];
    target_t target_q [$];
    longint  regs_copy [8];
    longint  pos_count;
    bit      idling_on = 1'b1;
    int      mismatches = 0;
    int      cells_sent = 0;
    int      results_seen = 0;
    int      positives_seen = 0;
    int      idle_cycles = 0;
    int      in_gap = 0;
    int      out_gap = 0;

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q--;
        return q;
    endfunction

    function automatic longint round_div(longint a, longint b);
        return floor_div(2 * a + b, 2 * b);
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic longint log2_fixed(longint x);
        longint e, t, frac;
        longint unsigned m;
        e = 0;
        t = x;
        frac = 0;
        while (t > 1)
        begin
            t = t >> 1;
            e++;
        end
        m = longint'(x) << (30 - e);
        for (int b = 15; b >= 0; b--)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31))
            begin
                m = m >> 1;
                frac = frac | (longint'(1) << b);
            end
        end
        return (e << 16) + frac;
    endfunction

    function automatic longint ln_ratio(longint num, longint den);
        if (num == 0)
            return -32768;
        return clip16(round_div((log2_fixed(num) - log2_fixed(den)) * 45426,
                                longint'(1) << 20));
    endfunction

    function automatic target_t assign_target(logic [6:0] c, logic [6:0] r);
        target_t res;
        longint left, top, tw, th, scale, px, py, dx, dy, lim;
        longint best_ov, best_un, wa, ha, aw, ah, al, ar, at, ab, lo, hi, ox, oy, ov, un;
        int best;
        bit best_ok, ok, better;
        res = '0;
        left = regs_copy[REG_LEFT];
        top = regs_copy[REG_TOP];
        tw = regs_copy[REG_WIDTH];
        th = regs_copy[REG_HEIGHT];
        scale = regs_copy[REG_SCALE] != 0 ? regs_copy[REG_SCALE] : 1;
        px = (longint'(c) * 8 + 4) * 65536 / scale;
        py = (longint'(r) * 8 + 4) * 65536 / scale;
        dx = regs_copy[REG_MASS_X] - px;
        dy = regs_copy[REG_MASS_Y] - py;
        lim = regs_copy[REG_LIMIT];
        if (dx * dx + dy * dy > lim * lim)
        begin
            res.total = pos_count[14:0];
            return res;
        end
        best = -1;
        best_ok = 0;
        best_ov = 0;
        best_un = 1;
        for (int k = 0; k < 5; k++)
        begin
            aw = ANCHOR_WIDTH[k];
            ah = aw * ANCHOR_RATIO[k];
            al = px - aw * 8;
            ar = px + aw * 8;
            at = py - ah * 8;
            ab = py + ah * 8;
            hi = (left + tw < ar) ? left + tw : ar;
            lo = (left > al) ? left : al;
            ox = hi - lo > 0 ? hi - lo : 0;
            hi = (top + th < ab) ? top + th : ab;
            lo = (top > at) ? top : at;
            oy = hi - lo > 0 ? hi - lo : 0;
            ov = ox * oy;
            un = tw * th + (aw * 16) * (ah * 16) - ov;
            ok = !(un * 100 < 256);
            if (best < 0)
                better = 1;
            else if (!ok)
                better = 0;
            else if (!best_ok)
                better = 1;
            else
                better = ov * best_un > best_ov * un;
            if (better)
            begin
                best = k;
                best_ok = ok;
                best_ov = ov;
                best_un = ok ? un : 1;
            end
        end
        wa = ANCHOR_WIDTH[best];
        ha = wa * ANCHOR_RATIO[best];
        if (pos_count < 32767)
            pos_count++;
        res.pos = 1'b1;
        res.anchor = best[2:0];
        res.off_x = 16'(clip16(round_div((2 * left + tw - 2 * px) * 128, wa)));
        res.off_y = 16'(clip16(round_div((2 * top + th - 2 * py) * 128, ha)));
        res.log_w = 16'(ln_ratio(tw, wa * 16));
        res.log_h = 16'(ln_ratio(th, ha * 16));
        res.total = pos_count[14:0];
        return res;
    endfunction

    // driver: predict on acceptance, then present the next item or idle
    always @(posedge clk or negedge rst_n)
    begin
        cell_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                target_q.push_back(assign_target(cell_col, cell_row));
                cells_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (cell_q.size() > 0)
                begin
                    nxt = cell_q.pop_front();
                    cell_col <= nxt.col;
                    cell_row <= nxt.row;
                    in_valid <= 1'b1;
                    if (idling_on && $urandom_range(0, 5) == 0)
                        in_gap = $urandom_range(1, 11);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        target_t exp_t, got;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                got = {is_positive, best_anchor, offset_x, offset_y, log_width_ratio,
                       log_height_ratio, positive_total};
                if (target_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item from dut: %p", got);
                end
                else
                begin
                    exp_t = target_q.pop_front();
                    positives_seen += exp_t.pos;
                    if (got !== exp_t)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p got %p", exp_t, got);
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (idling_on && $urandom_range(0, 5) == 0)
                    out_gap = $urandom_range(1, 11);
            end
        end
    end

    // watchdog on cycles with nothing accepted
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog expired, %0d items still expected", target_q.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        regs_copy[idx] = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_target(longint l, longint t, longint w, longint h,
                               longint mx, longint my, longint lim, longint sc);
        write_reg(REG_LEFT, 16'(l));
        write_reg(REG_TOP, 16'(t));
        write_reg(REG_WIDTH, 16'(w));
        write_reg(REG_HEIGHT, 16'(h));
        write_reg(REG_MASS_X, 16'(mx));
        write_reg(REG_MASS_Y, 16'(my));
        write_reg(REG_LIMIT, 16'(lim));
        write_reg(REG_SCALE, 16'(sc));
    endtask

    task automatic push_cell(int c, int r);
        cell_q.push_back({7'(c), 7'(r)});
    endtask

    // drain the block before the next register change
    task automatic settle();
        while (cell_q.size() > 0 || in_valid || target_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_scale();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hffff;
            3: return 16'($urandom);
            default: return 16'($urandom_range(2048, 8192));
        endcase
    endfunction

    initial
    begin
        longint sc, span, w, h;
        int c, r;
        regs_copy = '{0, 0, 0, 0, 0, 0, 0, 4096};
        pos_count = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: nothing is positive
        push_cell(0, 0);
        push_cell(127, 127);
        push_cell(0, 127);
        push_cell(127, 0);
        settle();

        // a typical target, inner and corner cells
        load_target(4800, 3200, 6400, 4800, 8000, 5600, 65535, 4096);
        push_cell(62, 43);
        push_cell(30, 20);
        push_cell(0, 0);
        push_cell(127, 127);
        push_cell(90, 10);
        push_cell(10, 90);
        settle();

        // zero limit hits only the exact cell; zero width and height
        load_target(500, 700, 0, 0, 704, 960, 0, 4096);
        push_cell(5, 7);
        push_cell(6, 7);
        push_cell(5, 8);
        settle();

        // scale zero treated as one, tall and wide targets
        load_target(0, 0, 16000, 48000, 704, 960, 65535, 0);
        push_cell(0, 0);
        push_cell(1, 1);
        push_cell(2, 0);
        settle();

        // all registers at their upper extreme
        load_target(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535);
        push_cell(127, 127);
        push_cell(0, 0);
        push_cell(64, 64);
        settle();

        for (int ph = 0; ph < 11; ph++)
        begin
            sc = pick_scale();
            span = (longint'(1020) * 65536) / (sc == 0 ? 1 : sc);
            if (span > 65535)
                span = 65535;
            w = $urandom_range(0, 7) == 0 ? longint'($urandom_range(0, 65535))
                                          : longint'($urandom_range(0, 8000));
            h = $urandom_range(0, 7) == 0 ? longint'($urandom_range(0, 65535))
                                          : longint'($urandom_range(0, 8000));
            load_target(longint'($urandom_range(0, 32'(span))),
                        longint'($urandom_range(0, 32'(span))), w, h,
                        longint'($urandom_range(0, 32'(span))),
                        longint'($urandom_range(0, 32'(span))),
                        $urandom_range(0, 2) == 0 ? longint'($urandom_range(0, 65535))
                                                  : 65535 - longint'($urandom_range(0, 9000)),
                        sc);
            if (ph == 10)
                idling_on = 1'b0;
            for (int i = 0; i < 150; i++)
            begin
                c = $urandom_range(0, 127);
                r = $urandom_range(0, 127);
                push_cell(c, r);
            end
            settle();
        end

        $display("covered %0d cells, %0d results, %0d of them positive, 16 register settings",
                 cells_sent, results_seen, positives_seen);
        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("status: fail");
        end
        $finish;
    end
endmodule
